@@ rtl/dntl_pkg.sv @@
// Shared types and constants for the decimal number token lexer.
`default_nettype none

package dntl_pkg;

   localparam int CHAR_W   = 21;
   localparam int MAG_W    = 63;
   localparam int VALUE_W  = 64;
   localparam int PLACES_W = 5;

   localparam logic [CHAR_W-1:0] CHR_ZERO   = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0] CHR_NINE   = CHAR_W'(8'h39);
   localparam logic [CHAR_W-1:0] CHR_MINUS  = CHAR_W'(8'h2D);
   localparam logic [CHAR_W-1:0] CHR_PERIOD = CHAR_W'(8'h2E);
   localparam logic [CHAR_W-1:0] CHR_SLASH  = CHAR_W'(8'h2F);
   localparam logic [CHAR_W-1:0] CHR_COMMA  = CHAR_W'(8'h2C);

   localparam logic [PLACES_W-1:0] MAX_PLACES = PLACES_W'(19);

   localparam logic CMD_FIRST = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   localparam logic [1:0] KIND_INT   = 2'd0;
   localparam logic [1:0] KIND_RATIO = 2'd1;
   localparam logic [1:0] KIND_DEC   = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_PERIODS  = 2'd1;
   localparam logic [1:0] STS_BAD_NUM  = 2'd2;
   localparam logic [1:0] STS_OVERFLOW = 2'd3;

   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_PERIOD,
      CLS_SLASH,
      CLS_COMMA,
      CLS_SIGN,
      CLS_END
   } cls_type;

   typedef struct packed {
      logic              command;
      logic [CHAR_W-1:0] character;
   } req_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] value;
      logic [MAG_W-1:0]          denominator;
      logic [PLACES_W-1:0]       decimal_places;
      logic                      char_not_consumed;
   } rsp_type;

   typedef struct packed {
      logic       command;
      cls_type    cls;
      logic [3:0] digit;
   } tok_type;

endpackage

`default_nettype wire

@@ rtl/dntl_front.sv @@
// Front end: classifies incoming characters and queues them for the back end.
`default_nettype none

module dntl_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dntl_pkg::req_type req_data,
   output logic                  q_valid,
   output dntl_pkg::tok_type     q_tok,
   input  wire logic             q_pop
);
   import dntl_pkg::*;

   tok_type    tok_ff [2];
   tok_type    tok_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   always_comb begin
      tok_in.command = req_data.command;
      tok_in.digit   = req_data.character[3:0];
      if (req_data.character inside {[CHR_ZERO:CHR_NINE]}) begin
         tok_in.cls = CLS_DIGIT;
      end else if (req_data.character == CHR_PERIOD) begin
         tok_in.cls = CLS_PERIOD;
      end else if (req_data.character == CHR_SLASH) begin
         tok_in.cls = CLS_SLASH;
      end else if (req_data.character == CHR_COMMA) begin
         tok_in.cls = CLS_COMMA;
      end else if (req_data.character == CHR_MINUS && req_data.command == CMD_FIRST) begin
         tok_in.cls = CLS_SIGN;
      end else begin
         tok_in.cls = CLS_END;
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_tok     = tok_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         tok_ff[wr_ptr_ff] <= tok_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dntl_back.sv @@
// Back end: token accumulator state and the result output register.
`default_nettype none

module dntl_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire dntl_pkg::tok_type q_tok,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dntl_pkg::rsp_type     rsp_data
);
   import dntl_pkg::*;

   logic                active_ff, active_in;
   logic                neg_ff, neg_in;
   logic                period_ff, period_in;
   logic                slash_ff, slash_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [VALUE_W-1:0]  num_ff, num_in;
   logic [PLACES_W-1:0] places_ff, places_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                b_neg, b_period, b_slash, live, res_fire;
   logic [MAG_W-1:0]    b_mag;
   logic [VALUE_W-1:0]  b_num, b_signed;
   logic [PLACES_W-1:0] b_places;
   logic [MAG_W+3:0]    prod_sum;
   rsp_type             res;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (q_tok.command == CMD_FIRST) begin
         b_neg    = 1'b0;
         b_period = 1'b0;
         b_slash  = 1'b0;
         b_mag    = '0;
         b_num    = '0;
         b_places = '0;
      end else begin
         b_neg    = neg_ff;
         b_period = period_ff;
         b_slash  = slash_ff;
         b_mag    = mag_ff;
         b_num    = num_ff;
         b_places = places_ff;
      end
      live     = (q_tok.command == CMD_FIRST) || active_ff;
      b_signed = b_neg ? (VALUE_W'(0) - {1'b0, b_mag}) : {1'b0, b_mag};
      prod_sum = {1'b0, b_mag, 3'b000} + {3'b000, b_mag, 1'b0}
               + {{MAG_W{1'b0}}, q_tok.digit};
   end

   always_comb begin
      active_in = active_ff;
      neg_in    = neg_ff;
      period_in = period_ff;
      slash_in  = slash_ff;
      mag_in    = mag_ff;
      num_in    = num_ff;
      places_in = places_ff;
      res_fire  = 1'b0;
      res.kind              = KIND_INT;
      res.status            = STS_OK;
      res.value             = '0;
      res.denominator       = MAG_W'(1);
      res.decimal_places    = '0;
      res.char_not_consumed = 1'b0;
      if (q_pop && live) begin
         active_in = 1'b1;
         neg_in    = b_neg;
         period_in = b_period;
         slash_in  = b_slash;
         mag_in    = b_mag;
         num_in    = b_num;
         places_in = b_places;
         case (q_tok.cls)
            CLS_SIGN: begin
               neg_in = 1'b1;
            end
            CLS_DIGIT: begin
               if ((|prod_sum[MAG_W+3:MAG_W]) || (b_period && b_places >= MAX_PLACES)) begin
                  res_fire   = 1'b1;
                  res.status = STS_OVERFLOW;
               end else begin
                  mag_in    = prod_sum[MAG_W-1:0];
                  places_in = b_places + PLACES_W'(b_period);
               end
            end
            CLS_PERIOD: begin
               if (b_period || b_slash) begin
                  res_fire   = 1'b1;
                  res.status = STS_PERIODS;
               end else begin
                  period_in = 1'b1;
               end
            end
            CLS_SLASH: begin
               if (b_period || b_slash) begin
                  res_fire   = 1'b1;
                  res.status = STS_BAD_NUM;
               end else begin
                  num_in   = b_signed;
                  mag_in   = '0;
                  slash_in = 1'b1;
               end
            end
            CLS_COMMA: begin
               active_in = 1'b1;
            end
            default: begin
               res_fire              = 1'b1;
               res.char_not_consumed = 1'b1;
               if (b_period) begin
                  res.kind           = KIND_DEC;
                  res.value          = b_signed;
                  res.decimal_places = b_places;
               end else if (b_slash) begin
                  res.kind        = KIND_RATIO;
                  res.value       = b_num;
                  res.denominator = b_mag;
               end else begin
                  res.value = b_signed;
               end
            end
         endcase
         if (res_fire) begin
            active_in = 1'b0;
            neg_in    = 1'b0;
            period_in = 1'b0;
            slash_in  = 1'b0;
            mag_in    = '0;
            num_in    = '0;
            places_in = '0;
         end
      end
   end

   always_comb begin
      if (res_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = res_fire ? res : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         neg_ff       <= 1'b0;
         period_ff    <= 1'b0;
         slash_ff     <= 1'b0;
         mag_ff       <= '0;
         num_ff       <= '0;
         places_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         neg_ff       <= neg_in;
         period_ff    <= period_in;
         slash_ff     <= slash_in;
         mag_ff       <= mag_in;
         num_ff       <= num_in;
         places_ff    <= places_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/decimal_number_token_lexer.sv @@
// Top level of the decimal number token lexer.
//
// Characters of a numeric token enter on the req_ channel, one transaction per
// character, with command low for the first character of a token. A token
// ends on a terminating character or on an error, and one transaction on the
// rsp_ channel then carries its kind, status, value, denominator and places.
// A transaction moves when valid is high and stall is low at a clock edge.
// The front end classifies each character into a two-entry queue, and the
// back end applies it to the accumulator, one character per cycle while no
// result waits on rsp_stall, with a single multiply by ten and add as the
// longest path. A result reaches rsp_valid through the queue and the result
// register, and characters flow at one per cycle while rsp_stall is low.
// While rsp_stall is high on a waiting result, the result register holds
// it, the queue fills and req_stall rises once both entries are taken.
// Synchronous reset empties the queue, drops any partial token and clears
// the result valid flag; req_stall is low in the first cycle after reset.
`default_nettype none

module decimal_number_token_lexer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dntl_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dntl_pkg::rsp_type     rsp_data
);
   import dntl_pkg::*;

   logic    q_valid;
   logic    q_pop;
   tok_type q_tok;

   dntl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_tok     (q_tok),
      .q_pop     (q_pop)
   );

   dntl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_tok     (q_tok),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STS_OK |->
         rsp_data.kind == KIND_INT && rsp_data.value == '0 &&
         rsp_data.denominator == MAG_W'(1) && rsp_data.decimal_places == '0 &&
         !rsp_data.char_not_consumed)
      else $error("Error result carries a non-default payload.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DEC |-> rsp_data.decimal_places == '0)
      else $error("Places reported on a result that is not decimal.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind != 2'd3)
      else $error("Result kind out of range.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("Queue filled without an accepted transaction.");

endmodule

`default_nettype wire
